>>> src/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define AST_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define AST_CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/b64d_pkg.sv
// Shared types, constants and character decode for the base64url stream decoder
package b64d_pkg;

	localparam int CountW = 12;
	localparam logic [CountW-1:0] CountMax = 12'd4095;
	localparam logic [CountW-1:0] ExpLenReset = 12'd54;

	// byte address of the expected_length register
	localparam logic [2:0] AddrExpLen = 3'd0;

	localparam int FifoDepth = 4;
	localparam int FifoPtrW = 2;
	localparam int FifoCntW = 3;

	localparam logic [5:0] DigitLowerBase = 6'd26;
	localparam logic [5:0] DigitNumBase = 6'd52;
	localparam logic [5:0] DigitDash = 6'd62;
	localparam logic [5:0] DigitUscore = 6'd63;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [5:0]        leftover_bits;
		logic [2:0]        leftover_count;
		logic [CountW-1:0] char_count;
		logic              error_seen;
	} tok_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		kind_t      kind;
		logic       run_last;
	} result_t;

	// up to two results written into the output queue in one cycle
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	// returns {valid, digit}
	function automatic logic [6:0] decode_char(input logic [7:0] c);
		logic [6:0] res;
		res = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			res = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			res = {1'b1, 6'(c - 8'h61) + DigitLowerBase};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			res = {1'b1, 6'(c - 8'h30) + DigitNumBase};
		end else if (c == 8'h2D) begin
			res = {1'b1, DigitDash};
		end else if (c == 8'h5F) begin
			res = {1'b1, DigitUscore};
		end
		return res;
	endfunction

endpackage

>>> src/base64url_stream_decoder.sv
// Unpadded base64url decoder: one character in, decoded bytes and end status out
//
// Input channel (in_valid/in_ready): one character per transfer, is_last on the
// final character of a token. Output channel (out_valid/out_ready): results of
// data_byte/kind/run_last; a character yields no result, a byte, an end status,
// or a byte followed by the end status. run_last marks the final result of a char.
// With an empty queue a result passes the stage 1 register and the result
// queue before it is presented on the output channel.
// Throughput: one character per cycle while the queue has room; the output
// drains one result per cycle, so the end status takes an extra output transfer
// and a four-entry result queue absorbs it. A character is taken into stage 1
// while results wait downstream. A stalled receiver fills the queue; stage 1
// holds once fewer than two free entries remain, then in_ready drops.
// expected_length is written over APB at address 0 (reset 54); the user must
// write it only while idle, which the block does not enforce. A rejected token
// may already have delivered bytes; the consumer drops them. Reset empties the
// queue and stage 1, clears the token state and restores expected_length.
`include "assert_macros.svh"

module base64url_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  kind,
	output logic        run_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [b64d_pkg::CountW-1:0]     exp_len_q;
	logic                            valid_s1;
	logic [7:0]                      char_s1;
	logic                            last_s1;
	logic                            fire_s1;
	logic                            room;
	b64d_pkg::tok_state_t            state_q;
	b64d_pkg::tok_state_t            state_d;
	b64d_pkg::push_t                 step_push;
	b64d_pkg::push_t                 fifo_push;
	b64d_pkg::result_t               head;
	logic [b64d_pkg::FifoCntW-1:0]   fifo_count;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == b64d_pkg::AddrExpLen[2]) ? {20'd0, exp_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= b64d_pkg::ExpLenReset;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == b64d_pkg::AddrExpLen[2])) begin
			exp_len_q <= pwdata[b64d_pkg::CountW-1:0];
		end
	end

	// stage 1 input register
	assign fire_s1 = valid_s1 && room;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= character;
			last_s1 <= is_last;
		end
	end

	b64d_step u_step (
		.state_q   (state_q),
		.exp_len   (exp_len_q),
		.character (char_s1),
		.is_last   (last_s1),
		.state_d   (state_d),
		.push      (step_push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		fifo_push = step_push;
		if (!fire_s1) begin
			fifo_push.num = 2'd0;
		end
	end

	b64d_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.pop       (out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room      (room),
		.count     (fifo_count)
	);

	assign data_byte = head.data_byte;
	assign kind = head.kind;
	assign run_last = head.run_last;

	`AST_CHK(a_fifo_bound, fifo_count <= b64d_pkg::FifoCntW'(b64d_pkg::FifoDepth), "result queue overflow")
	`AST_CHK(a_last_clears, (fire_s1 && last_s1) |=> (state_q.char_count == '0 && !state_q.error_seen), "token state not cleared after last char")
	`AST_CHK(a_status_form, (out_valid && kind != b64d_pkg::KIND_BYTE) |-> (data_byte == 8'd0 && run_last), "end status with data or without run_last")
	`AST_CHK(a_even_leftover, state_q.leftover_count[0] == 1'b0, "odd leftover bit count")

endmodule

>>> src/b64d_step.sv
// Per-character decode: next token state and the results one character causes
module b64d_step (
	input  b64d_pkg::tok_state_t         state_q,
	input  logic [b64d_pkg::CountW-1:0]  exp_len,
	input  logic [7:0]                   character,
	input  logic                         is_last,
	output b64d_pkg::tok_state_t         state_d,
	output b64d_pkg::push_t              push
);

	logic [6:0]                  dec;
	logic                        dig_ok;
	logic [5:0]                  digit;
	logic [b64d_pkg::CountW:0]   position;
	logic                        err;
	logic [11:0]                 acc;
	logic [3:0]                  cnt_full;
	logic [2:0]                  cnt_rem;
	logic [11:0]                 shifted;
	logic [11:0]                 mask;
	logic [11:0]                 masked;
	logic                        byte_out;
	logic                        ok;
	b64d_pkg::tok_state_t        nxt;
	b64d_pkg::result_t           byte_res;
	b64d_pkg::result_t           end_res;

	always_comb begin
		dec = b64d_pkg::decode_char(character);
		dig_ok = dec[6];
		digit = dec[5:0];
		position = {1'b0, state_q.char_count} + {{b64d_pkg::CountW{1'b0}}, 1'b1};
		err = state_q.error_seen || !dig_ok || (position > {1'b0, exp_len});

		acc = {state_q.leftover_bits, digit};
		cnt_full = {1'b0, state_q.leftover_count} + 4'd6;
		cnt_rem = 3'(cnt_full - 4'd8);
		shifted = acc >> cnt_rem;
		mask = (12'd1 << cnt_rem) - 12'd1;
		masked = acc & mask;

		nxt = state_q;
		nxt.error_seen = err;
		nxt.char_count = position[b64d_pkg::CountW] ? b64d_pkg::CountMax
			: position[b64d_pkg::CountW-1:0];
		byte_out = 1'b0;
		if (dig_ok) begin
			if (cnt_full >= 4'd8) begin
				byte_out = !err;
				nxt.leftover_bits = masked[5:0];
				nxt.leftover_count = cnt_rem;
			end else begin
				nxt.leftover_bits = acc[5:0];
				nxt.leftover_count = cnt_full[2:0];
			end
		end

		// single dangling char leaves six bits: not a legal unpadded length
		ok = !err && (position == {1'b0, exp_len}) && (nxt.leftover_count != 3'd6)
			&& (nxt.leftover_bits == 6'd0);

		byte_res.data_byte = shifted[7:0];
		byte_res.kind = b64d_pkg::KIND_BYTE;
		byte_res.run_last = !is_last;
		end_res.data_byte = 8'd0;
		end_res.kind = ok ? b64d_pkg::KIND_ACCEPT : b64d_pkg::KIND_REJECT;
		end_res.run_last = 1'b1;

		state_d = nxt;
		if (is_last) begin
			state_d = '0;
		end

		push.num = {1'b0, byte_out} + {1'b0, is_last};
		push.r0 = byte_out ? byte_res : end_res;
		push.r1 = end_res;
	end

endmodule

>>> src/b64d_result_fifo.sv
// Four-entry result queue, up to two writes and one read per cycle
module b64d_result_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  b64d_pkg::push_t                 push,
	input  logic                            pop,
	output b64d_pkg::result_t               head,
	output logic                            not_empty,
	output logic                            room,
	output logic [b64d_pkg::FifoCntW-1:0]   count
);

	b64d_pkg::result_t                mem_q [b64d_pkg::FifoDepth];
	logic [b64d_pkg::FifoPtrW-1:0]    wr_ptr_q;
	logic [b64d_pkg::FifoPtrW-1:0]    rd_ptr_q;
	logic [b64d_pkg::FifoCntW-1:0]    count_q;
	logic                             do_pop;

	assign not_empty = (count_q != '0);
	assign do_pop = pop && not_empty;
	assign head = mem_q[rd_ptr_q];
	assign count = count_q;
	assign room = (count_q <= b64d_pkg::FifoCntW'(b64d_pkg::FifoDepth - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + b64d_pkg::FifoPtrW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + b64d_pkg::FifoPtrW'(push.num);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + b64d_pkg::FifoPtrW'(1);
			end
			count_q <= count_q + b64d_pkg::FifoCntW'(push.num)
				- b64d_pkg::FifoCntW'(do_pop);
		end
	end

endmodule
